### hw/rtl/dpq_pkg.sv
// Shared constants and types for the double-ended priority queue.
`timescale 1ns / 1ps

package dpq_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 11;
    localparam int VAL_W    = 32;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic signed [VAL_W-1:0] val_t;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_MAX    = 2'd1,
        REQ_MIN    = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

endpackage

### hw/rtl/dpq_store.sv
// Value store: one write port and one registered read port.
`timescale 1ns / 1ps

module dpq_store
    import dpq_pkg::*;
(
    input  logic clk,
    input  logic we,
    input  idx_t waddr,
    input  val_t wdata,
    input  idx_t raddr,
    output val_t rdata
);

    val_t mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/double_ended_priority_queue_unit.sv
// Top level of the double-ended priority queue.
`timescale 1ns / 1ps
// Double-ended priority queue of signed 32-bit values, up to 1024 held.
// Slave channel (s_*) takes one request beat: insert a value, remove the
// maximum or remove the minimum. Master channel (m_*) returns exactly one
// result beat per request: the removed value (zero otherwise), a status
// (done, empty, full) and the number of values held afterwards.
// Values sit in ascending order in a circular buffer held in a single
// memory with a registered read port; head points at the minimum.
// A removal reads the memory once to fetch the removed value.
// An insert walks down from the maximum, comparing each entry with the new
// value and shifting larger entries up one place, one entry at a time
// through the shared compare and the single read port.
// Full inserts, empty removals and the unused code answer without a memory access.
// One request is in flight at a time: s_tready is high only when idle,
// in the cycle after the result beat is taken, and a finished result is held
// on m_tdata while m_tready is low.
// Reset (rst_n low, asynchronous) empties the queue at once; the memory
// needs no clearing because only entries below the count are read.

module double_ended_priority_queue_unit
    import dpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [1:0] req_type, [33:2] value, [39:34] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [31:0] out_value, [33:32] status,
                                   // [44:34] count, [47:45] zero
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_RD_TAKE,
        S_OUT
    } state_t;

    state_t  state_reg;
    idx_t    head_reg;
    cnt_t    count_reg;
    cnt_t    j_reg;
    val_t    key_reg;
    req_t    req_reg;
    val_t    out_value_reg;
    status_t status_reg;

    req_t in_req;
    val_t in_value;

    logic ram_we;
    idx_t ram_waddr;
    val_t ram_wdata;
    idx_t ram_raddr;
    val_t ram_rdata;
    logic greater;

    assign in_req   = req_t'(s_tdata[1:0]);
    assign in_value = val_t'(s_tdata[33:2]);
    assign greater  = ram_rdata > key_reg;

    dpq_store u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Memory port control: the read address is issued in the cycle before its data is used.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = head_reg + j_reg[IDX_W-1:0];
        ram_wdata = key_reg;
        ram_raddr = head_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_req == REQ_MAX)
                begin
                    ram_raddr = head_reg + count_reg[IDX_W-1:0] - idx_t'(1);
                end
            end
            S_INS_RD:
            begin
                ram_raddr = head_reg + j_reg[IDX_W-1:0] - idx_t'(1);
                ram_we    = (j_reg == '0);
            end
            S_INS_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = greater ? ram_rdata : key_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            j_reg         <= '0;
            key_reg       <= '0;
            req_reg       <= REQ_NONE;
            out_value_reg <= '0;
            status_reg    <= ST_DONE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        out_value_reg <= '0;
                        status_reg    <= ST_DONE;
                        req_reg       <= in_req;
                        unique case (in_req)
                            REQ_INSERT:
                            begin
                                if (count_reg == cnt_t'(CAPACITY))
                                begin
                                    status_reg <= ST_FULL;
                                    state_reg  <= S_OUT;
                                end
                                else
                                begin
                                    key_reg   <= in_value;
                                    j_reg     <= count_reg;
                                    state_reg <= S_INS_RD;
                                end
                            end
                            REQ_MAX, REQ_MIN:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_RD_TAKE;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_INS_RD:
                begin
                    // empty slot has reached the bottom: value lands there
                    if (j_reg == '0)
                    begin
                        count_reg <= count_reg + cnt_t'(1);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_INS_CMP;
                    end
                end
                S_INS_CMP:
                begin
                    if (greater)
                    begin
                        j_reg     <= j_reg - cnt_t'(1);
                        state_reg <= S_INS_RD;
                    end
                    else
                    begin
                        count_reg <= count_reg + cnt_t'(1);
                        state_reg <= S_OUT;
                    end
                end
                S_RD_TAKE:
                begin
                    out_value_reg <= ram_rdata;
                    count_reg     <= count_reg - cnt_t'(1);
                    if (req_reg == REQ_MIN)
                    begin
                        head_reg <= head_reg + idx_t'(1);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {3'b000, count_reg, status_reg, out_value_reg};

endmodule
